@@ rtl/core/stepped_sine_sweep_generator_assert.svh @@
// Assertion macros for the stepped sine sweep generator checker.
// Included by the checker only; needs nothing else.
`ifndef STEPPED_SINE_SWEEP_GENERATOR_ASSERT_SVH
`define STEPPED_SINE_SWEEP_GENERATOR_ASSERT_SVH

// Condition in one cycle implies a condition in the next.
`define SSG_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
		else $error("assertion failed");

// Condition implies a condition a fixed number of cycles later.
`define SSG_ASSERT_LATER(label, clk, rst_n, cond, n, conseq) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ##n (conseq)) \
		else $error("assertion failed");

`endif

@@ rtl/core/ssg_pkg.sv @@
// Shared types, register indexes and the cosine table function.
// No dependencies.
`timescale 1ns / 1ps

package ssg_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLES     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 3'd6;

	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam logic [63:0] ONE_Q30    = 64'd1073741824;

	// Scaling settings used by the sample path
	typedef struct packed {
		logic [14:0]        amplitude;
		logic signed [15:0] bias;
	} sample_cfg_t;

	// Rounded, capped cosine magnitude for quarter-wave step k (elaboration only)
	function automatic logic [63:0] cos_mag(input int k, input int tb, input int sb);
		logic [63:0] theta;
		logic [63:0] th2;
		logic [63:0] t;
		logic [63:0] q;
		logic [63:0] mag;
		logic [63:0] cap;
		theta = (64'(k) * TWO_PI_Q30) >> tb;
		th2 = (theta * theta) >> 30;
		t = ONE_Q30;
		// Evaluate the series from the highest term down
		q = ((t * th2) >> 30) / 64'd182;
		t = (q > ONE_Q30) ? 64'd0 : ONE_Q30 - q;
		q = ((t * th2) >> 30) / 64'd132;
		t = (q > ONE_Q30) ? 64'd0 : ONE_Q30 - q;
		q = ((t * th2) >> 30) / 64'd90;
		t = (q > ONE_Q30) ? 64'd0 : ONE_Q30 - q;
		q = ((t * th2) >> 30) / 64'd56;
		t = (q > ONE_Q30) ? 64'd0 : ONE_Q30 - q;
		q = ((t * th2) >> 30) / 64'd30;
		t = (q > ONE_Q30) ? 64'd0 : ONE_Q30 - q;
		q = ((t * th2) >> 30) / 64'd12;
		t = (q > ONE_Q30) ? 64'd0 : ONE_Q30 - q;
		q = ((t * th2) >> 30) / 64'd2;
		t = (q > ONE_Q30) ? 64'd0 : ONE_Q30 - q;
		mag = (t + (64'd1 << (30 - sb))) >> (31 - sb);
		cap = (64'd1 << (sb - 1)) - 64'd1;
		if (mag > cap) begin
			mag = cap;
		end
		return mag;
	endfunction

endpackage

@@ rtl/core/stepped_sine_sweep_generator.sv @@
// Channel  | Handshake             | Payload
// cfg      | cfg_valid/cfg_ready   | cfg_index, cfg_data
// in       | in_valid/in_ready     | time_now
// out      | out_valid/out_ready   | frequency, signal_out, sweep_done
// The front end takes one time stamp at a time through capture, 32x32 multiply and state update;
// the update waits for queue space. The sample path takes one item at a time through fold, table,
// scale multiply, bias/saturate and hold, and leaves hold only while out_ready is high.
// A two-entry queue lets the front run ahead while a result waits on out_ready.
// arst_n clears the sequencers, queue and configuration to defaults; cfg_ready is always high.
// Top level of the stepped sine sweep generator; depends on ssg_pkg and the ssg_* modules.
`timescale 1ns / 1ps

module stepped_sine_sweep_generator import ssg_pkg::*; #(
	parameter int COS_TABLE_BITS = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          time_now,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          frequency,
	output logic signed [15:0]   signal_out,
	output logic                 sweep_done
);

	localparam int ENTRY_W = COS_TABLE_BITS + 34;

	logic               push_valid, push_ready, pop_valid, pop_ready;
	logic [ENTRY_W-1:0] push_data, pop_data;
	sample_cfg_t        scfg;

	assign cfg_ready = 1'b1;

	ssg_front #(.COS_TABLE_BITS(COS_TABLE_BITS), .ENTRY_W(ENTRY_W)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .time_now(time_now),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
		.scfg(scfg)
	);

	ssg_queue #(.WIDTH(ENTRY_W)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
	);

	ssg_back #(
		.COS_TABLE_BITS(COS_TABLE_BITS), .SAMPLE_BITS(SAMPLE_BITS), .ENTRY_W(ENTRY_W)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
		.scfg(scfg),
		.out_valid(out_valid), .out_ready(out_ready),
		.frequency(frequency), .signal_out(signal_out), .sweep_done(sweep_done)
	);

endmodule

@@ rtl/core/ssg_front.sv @@
// Front end: configuration registers, sweep state and the phase product.
// Depends on ssg_pkg.
`timescale 1ns / 1ps

module ssg_front import ssg_pkg::*; #(
	parameter int COS_TABLE_BITS = 10,
	parameter int ENTRY_W = COS_TABLE_BITS + 34
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          time_now,
	output logic                 push_valid,
	input  logic                 push_ready,
	output logic [ENTRY_W-1:0]   push_data,
	output sample_cfg_t          scfg
);

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

	fstate_t     state_q;
	logic [31:0] freq_max_q, freq_step_q, start_time_q;
	logic [15:0] cycles_q;
	logic [14:0] amplitude_q;
	logic [15:0] bias_q;
	logic [31:0] cur_freq_q, seg_start_q;
	logic        ended_q;
	logic [31:0] rel_q, elapsed_q;
	logic        live_q;
	logic [63:0] prod_q;

	logic        step_hit;
	logic [32:0] freq_sum;
	logic [31:0] freq_next;
	logic        ended_next;

	assign in_ready = (state_q == F_IDLE);
	assign scfg.amplitude = amplitude_q;
	assign scfg.bias = bias_q;

	// Decide the segment update from the registered product
	always_comb begin
		step_hit = live_q && (prod_q[63:32] >= {16'd0, cycles_q});
		freq_sum = {1'b0, cur_freq_q} + {1'b0, freq_step_q};
		freq_next = cur_freq_q;
		ended_next = ended_q;
		if (step_hit) begin
			if (cur_freq_q <= freq_max_q) begin
				freq_next = freq_sum[32] ? 32'hFFFF_FFFF : freq_sum[31:0];
			end else begin
				ended_next = 1'b1;
			end
		end
	end

	assign push_valid = (state_q == F_PUSH);
	assign push_data = {freq_next, ended_next, live_q,
		prod_q[31 -: COS_TABLE_BITS]};

	// Hold configuration and sweep state, advance the front sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			freq_max_q <= 32'd4096000;
			freq_step_q <= 32'd4096;
			cycles_q <= 16'd10;
			amplitude_q <= 15'd16384;
			bias_q <= 16'd0;
			start_time_q <= 32'd0;
			cur_freq_q <= 32'd4096;
			seg_start_q <= 32'd0;
			ended_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_FREQ_MIN: begin
						cur_freq_q <= cfg_data;
						seg_start_q <= 32'd0;
						ended_q <= 1'b0;
					end
					REG_FREQ_MAX:   freq_max_q <= cfg_data;
					REG_FREQ_STEP:  freq_step_q <= cfg_data;
					REG_CYCLES:     cycles_q <= cfg_data[15:0];
					REG_AMPLITUDE:  amplitude_q <= cfg_data[14:0];
					REG_BIAS:       bias_q <= cfg_data[15:0];
					REG_START_TIME: start_time_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: state_q <= F_PUSH;
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
						cur_freq_q <= freq_next;
						ended_q <= ended_next;
						if (step_hit && !ended_next) begin
							seg_start_q <= rel_q;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Capture the time stamp and form the phase product
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			rel_q <= time_now - start_time_q;
			elapsed_q <= time_now - start_time_q - seg_start_q;
			live_q <= (time_now >= start_time_q) && !ended_q;
		end
		if (state_q == F_MUL) begin
			prod_q <= 64'(cur_freq_q) * 64'(elapsed_q);
		end
	end

endmodule

@@ rtl/core/ssg_queue.sv @@
// Two-entry queue between the front end and the sample path.
// No dependencies.
`timescale 1ns / 1ps

module ssg_queue #(
	parameter int WIDTH = 44
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/ssg_back.sv @@
// Sample path: quarter-wave cosine lookup, amplitude scaling, bias and output register.
// Depends on ssg_pkg.
`timescale 1ns / 1ps

module ssg_back import ssg_pkg::*; #(
	parameter int COS_TABLE_BITS = 10,
	parameter int SAMPLE_BITS = 16,
	parameter int ENTRY_W = COS_TABLE_BITS + 34
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  logic [ENTRY_W-1:0] pop_data,
	input  sample_cfg_t        scfg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        frequency,
	output logic signed [15:0] signal_out,
	output logic               sweep_done
);

	localparam int CB = COS_TABLE_BITS;
	localparam int QUARTER = 1 << (CB - 2);
	localparam int MW = SAMPLE_BITS - 1;
	localparam int PW = 15 + SAMPLE_BITS;

	typedef enum logic [2:0] {B_IDLE, B_TBL, B_MUL, B_SUM, B_HOLD} bstate_t;

	bstate_t        state_q;
	logic [CB-2:0]  k_q;
	logic           neg_q, live_q, done_q;
	logic [31:0]    freq_q;
	logic [MW-1:0]  mag_q;
	logic [14:0]    sc_q;

	logic [MW-1:0]  mag_tbl [QUARTER+1];
	logic [CB-1:0]  idx;
	logic [1:0]     quad;
	logic [CB-3:0]  r;
	logic [CB-2:0]  k;
	logic [PW-1:0]  scaled;
	logic signed [17:0] sum;
	logic signed [15:0] sample;

	// Quarter-wave magnitude table, built at elaboration
	for (genvar g = 0; g <= QUARTER; g++) begin : g_tbl
		localparam logic [63:0] M = cos_mag(g, CB, SAMPLE_BITS);
		assign mag_tbl[g] = M[MW-1:0];
	end

	// Fold the phase index into a quarter wave
	always_comb begin
		idx = pop_data[CB-1:0];
		quad = idx[CB-1:CB-2];
		r = idx[CB-3:0];
		k = quad[0] ? ((CB-1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
	end

	// Scale by amplitude with half-up rounding, then add bias and saturate
	always_comb begin
		scaled = PW'(scfg.amplitude) * PW'(mag_q) + (PW'(1) << (SAMPLE_BITS - 2));
		sum = neg_q ? (18'(scfg.bias) - $signed({3'b000, sc_q}))
			: (18'(scfg.bias) + $signed({3'b000, sc_q}));
		if (!live_q) begin
			sample = scfg.bias;
		end else if (sum > 18'sd32767) begin
			sample = 16'sh7FFF;
		end else if (sum < -18'sd32768) begin
			sample = 16'sh8000;
		end else begin
			sample = sum[15:0];
		end
	end

	assign pop_ready = (state_q == B_IDLE);
	assign out_valid = (state_q == B_HOLD);

	// Sequence one entry through lookup, scaling and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						state_q <= B_TBL;
					end
				end
				B_TBL:  state_q <= B_MUL;
				B_MUL:  state_q <= B_SUM;
				B_SUM:  state_q <= B_HOLD;
				B_HOLD: begin
					if (out_ready) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					k_q <= k;
					neg_q <= (quad == 2'd1) || (quad == 2'd2);
					live_q <= pop_data[CB];
					done_q <= pop_data[CB+1];
					freq_q <= pop_data[CB+33:CB+2];
				end
			end
			B_TBL: mag_q <= mag_tbl[k_q];
			B_MUL: sc_q <= scaled[MW +: 15];
			B_SUM: begin
				frequency <= freq_q;
				sweep_done <= done_q;
				signal_out <= sample;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/core/ssg_checker.sv @@
// Port-level checks for the sweep generator, bound to the top level.
// Depends on stepped_sine_sweep_generator_assert.svh.
`timescale 1ns / 1ps
`include "stepped_sine_sweep_generator_assert.svh"

module ssg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] frequency,
	input logic [15:0] signal_out,
	input logic        sweep_done
);

	// Stalled result holds
	`SSG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`SSG_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(frequency) && $stable(signal_out) && $stable(sweep_done))
	// Front stays busy for multiply and update after a transaction
	`SSG_ASSERT_NEXT(a_front_busy1, clk, arst_n, in_valid && in_ready, !in_ready)
	`SSG_ASSERT_LATER(a_front_busy2, clk, arst_n, in_valid && in_ready, 2, !in_ready)

endmodule

bind stepped_sine_sweep_generator ssg_checker u_ssg_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.frequency(frequency), .signal_out(signal_out), .sweep_done(sweep_done)
);

@@ tb/tb_stepped_sine_sweep_generator.sv @@
// Self-checking testbench for the stepped sine sweep generator.
// Predicts frequency, sample and done flag per time stamp; depends on ssg_pkg and the RTL.
`timescale 1ns / 1ps

module tb_stepped_sine_sweep_generator;
	import ssg_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [31:0]          time_now;
	logic                 out_valid;
	logic                 out_ready;
	logic [31:0]          frequency;
	logic signed [15:0]   signal_out;
	logic                 sweep_done;

	typedef struct packed {
		logic [31:0]        freq;
		logic signed [15:0] sample;
		logic               done;
	} sweep_sample_t;

	// Predictor copy of the registers and sweep state
	logic [31:0]        p_freq_min, p_freq_max, p_freq_step, p_start;
	logic [15:0]        p_cycles;
	logic [14:0]        p_amp;
	logic signed [15:0] p_bias;
	logic [31:0]        p_cur_freq, p_seg_start;
	logic               p_ended;

	sweep_sample_t expected_samples[$];
	int  error_count;
	int  sample_count;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_receiver;

	stepped_sine_sweep_generator i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .time_now(time_now),
		.out_valid(out_valid), .out_ready(out_ready), .frequency(frequency),
		.signal_out(signal_out), .sweep_done(sweep_done)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Cosine magnitude in Q30 for quarter-wave step k
	function automatic logic [63:0] cos_q30(input logic [31:0] k);
		logic [63:0] theta, th2, t, q;
		logic [63:0] divs [7];
		divs = '{64'd182, 64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};
		theta = ({32'd0, k} * 64'd6746518852) >> 10;
		th2 = (theta * theta) >> 30;
		t = 64'd1073741824;
		for (int i = 0; i < 7; i++) begin
			q = ((t * th2) >> 30) / divs[i];
			t = (q > 64'd1073741824) ? 64'd0 : 64'd1073741824 - q;
		end
		return t;
	endfunction

	function automatic logic signed [15:0] sample_of(input logic [31:0] frac);
		logic [9:0]  idx;
		logic [1:0]  quad;
		logic [31:0] k;
		logic [63:0] mag, sc;
		longint      v;
		idx = frac[31:22];
		quad = idx[9:8];
		k = quad[0] ? 32'd256 - idx[7:0] : {24'd0, idx[7:0]};
		mag = (cos_q30(k) + 64'd16384) >> 15;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		sc = ({49'd0, p_amp} * mag + 64'd16384) >> 15;
		v = (quad == 2'd1 || quad == 2'd2) ? longint'(p_bias) - longint'(sc)
			: longint'(p_bias) + longint'(sc);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	// Advance the predicted sweep by one time stamp
	function automatic sweep_sample_t sweep_predict(input logic [31:0] t);
		sweep_sample_t r;
		logic [31:0] rel, el;
		logic [63:0] prod, nf;
		r.sample = p_bias;
		if (t >= p_start && !p_ended) begin
			rel = t - p_start;
			el = rel - p_seg_start;
			prod = {32'd0, p_cur_freq} * {32'd0, el};
			r.sample = sample_of(prod[31:0]);
			if (prod[63:32] >= {16'd0, p_cycles}) begin
				if (p_cur_freq <= p_freq_max) begin
					nf = {32'd0, p_cur_freq} + {32'd0, p_freq_step};
					p_seg_start = rel;
					p_cur_freq = (nf > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nf[31:0];
				end else begin
					p_ended = 1'b1;
				end
			end
		end
		r.freq = p_cur_freq;
		r.done = p_ended;
		return r;
	endfunction

	function automatic void predictor_reset();
		p_freq_min = 32'd4096;
		p_freq_max = 32'd4096000;
		p_freq_step = 32'd4096;
		p_cycles = 16'd10;
		p_amp = 15'd16384;
		p_bias = 16'sd0;
		p_start = 32'd0;
		p_cur_freq = 32'd4096;
		p_seg_start = 32'd0;
		p_ended = 1'b0;
	endfunction

	// Write one register; block must be idle; caller drops cfg_valid
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FREQ_MIN: begin
				p_freq_min = val;
				p_cur_freq = val;
				p_seg_start = 32'd0;
				p_ended = 1'b0;
			end
			REG_FREQ_MAX:   p_freq_max = val;
			REG_FREQ_STEP:  p_freq_step = val;
			REG_CYCLES:     p_cycles = val[15:0];
			REG_AMPLITUDE:  p_amp = val[14:0];
			REG_BIAS:       p_bias = val[15:0];
			REG_START_TIME: p_start = val;
			default: ;
		endcase
	endtask

	// Send one time stamp transaction, with random idle before it
	task automatic send_time(input logic [31:0] t);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		time_now <= t;
		do @(posedge clk); while (!in_ready);
		expected_samples.push_back(sweep_predict(t));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] fmin, fmax, fstep, cyc, amp, b, st);
		drain();
		write_reg(REG_FREQ_MAX, fmax);
		write_reg(REG_FREQ_STEP, fstep);
		write_reg(REG_CYCLES, cyc);
		write_reg(REG_AMPLITUDE, amp);
		write_reg(REG_BIAS, b);
		write_reg(REG_START_TIME, st);
		write_reg(REG_FREQ_MIN, fmin);
		cfg_valid <= 1'b0;
	endtask

	// Directed: field extremes, before start, wrap of time, saturating frequency
	task automatic test_directed();
		send_time(32'd0);
		send_time(32'd1);
		send_time(32'd100000);
		send_time(32'd50);
		send_time(32'hFFFF_FFFF);
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd32767,
			32'h0000_7FFF, 32'h8000_0000);
		send_time(32'd5);
		send_time(32'h8000_0000);
		send_time(32'h8000_0003);
		send_time(32'hFFFF_FFFF);
		configure(32'd1, 32'd1, 32'd0, 32'd65535, 32'd0, 32'hFFFF_8000, 32'd0);
		send_time(32'd0);
		send_time(32'hFFFF_FFFF);
		configure(32'd4096, 32'd1, 32'd4096, 32'd0, 32'd32767, 32'hFFFF_8000, 32'd7);
		send_time(32'd7);
		send_time(32'd8);
		send_time(32'd9);
		configure(32'd0, 32'd0, 32'd1, 32'd0, 32'd32767, 32'd0, 32'd0);
		send_time(32'd3);
		send_time(32'd4);
	endtask

	// Random sweeps with monotone time and occasional noise stamps
	task automatic test_random_sweeps(input int n_items);
		logic [31:0] t;
		int k;
		k = 0;
		while (k < n_items) begin
			configure($urandom_range(4096 * 2000, 1), $urandom(),
				($urandom_range(3) == 0) ? $urandom() : $urandom_range(4096 * 500),
				$urandom_range(4, 0), $urandom_range(32767), $urandom(),
				($urandom_range(1) == 0) ? 32'd0 : $urandom());
			t = ($urandom_range(1) == 0) ? $urandom() : p_start - $urandom_range(50);
			for (int j = 0; j < 150; j++) begin
				if ($urandom_range(19) == 0)
					send_time($urandom());
				else begin
					t = t + $urandom_range(4000);
					send_time(t);
				end
				k++;
			end
		end
	endtask

	// Hold off the receiver so the queue fills and stalls the input
	task automatic test_backpressure();
		hold_receiver = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_receiver = 1'b0;
			end
			begin
				for (int j = 0; j < 20; j++) send_time(32'd1000 * j);
				in_valid <= 1'b0;
			end
		join
	endtask

	// Receiver readiness
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !hold_receiver && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		sweep_sample_t exp_s;
		if (arst_n && out_valid && out_ready) begin
			sample_count++;
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected result freq=%0d sig=%0d done=%0b", $time,
					frequency, signal_out, sweep_done);
				error_count++;
			end else begin
				exp_s = expected_samples.pop_front();
				if (exp_s.freq != frequency) begin
					$display("%0t: frequency expected %0d actual %0d", $time,
						exp_s.freq, frequency);
					error_count++;
				end
				if (exp_s.sample != signal_out) begin
					$display("%0t: signal_out expected %0d actual %0d", $time,
						exp_s.sample, signal_out);
					error_count++;
				end
				if (exp_s.done != sweep_done) begin
					$display("%0t: sweep_done expected %0b actual %0b", $time,
						exp_s.done, sweep_done);
					error_count++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		error_count = 0;
		sample_count = 0;
		hold_receiver = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		time_now = '0;
		predictor_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 34;
		recv_idle_pct = 62;
		test_random_sweeps(600);
		send_idle_pct = 62;
		recv_idle_pct = 34;
		test_random_sweeps(600);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_sweeps(600);
		drain();
		if (expected_samples.size() != 0) error_count++;
		$display("Covered %0d samples over directed edge cases and random sweeps,", sample_count);
		$display("with sender/receiver idling and a long output hold-off.");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
